>>> design/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and constants for the Sauvola local threshold block.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WINDOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_K_FACTOR     = 2'd3;

  localparam logic [8:0]  RST_IMAGE_HEIGHT = 9'd256;
  localparam logic [8:0]  RST_IMAGE_WIDTH  = 9'd256;
  localparam logic [7:0]  RST_HALF_WINDOW  = 8'd7;
  localparam logic [16:0] RST_K_FACTOR     = 17'd13107;

  localparam logic       FUNC_LOAD = 1'b0;
  localparam logic       FUNC_EMIT = 1'b1;
  localparam logic [7:0] BIN_FG    = 8'd255;
  localparam logic [7:0] BIN_BG    = 8'd0;

  localparam int DIV_W    = 64;
  localparam int SQRT_W   = 48;
  localparam int SQRT_ITR = 24;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TOTAL,
    ST_DIV,
    ST_LD_RD,
    ST_LD_WR,
    ST_EM_WIN,
    ST_EM_AREA,
    ST_EM_RD,
    ST_EM_M0,
    ST_EM_M1,
    ST_EM_M2,
    ST_EM_M3,
    ST_EM_MEAN,
    ST_EM_VQ,
    ST_EM_VF,
    ST_EM_SQRT,
    ST_EM_DEV,
    ST_EM_TERM,
    ST_EM_RHS,
    ST_EM_CMP,
    ST_EM_OUT
  } state_e;

endpackage

>>> design/sauvola_local_threshold.sv
// ----------------------------------------------------------------------------
// sauvola_local_threshold
// Sauvola binarizer over integral images of pixel sums and squared sums,
// built from loaded pixels and read back one binarized pixel per emit item.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------
//  in      | input     | in_valid_i / in_stall_o  | func_i, pixel_in_i
//  out     | output    | out_valid_o / out_stall_i| bin_pixel_o, last_o
//  cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
//  For a load item the raster index is split into row and column by a
//  bit-serial divider (IW steps), then one table read and one write. For an
//  emit item the shared divider runs four times (index, mean, variance,
//  variance fraction: IW+32+64+64 steps), the square root takes 24 steps,
//  and the single shared multiplier handles seven products.
//  The input is stalled while an item is in work. Reset clears the counters;
//  the tables need no clearing.
// ----------------------------------------------------------------------------
module sauvola_local_threshold #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           func_i,
  input  logic [7:0]                     pixel_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     bin_pixel_o,
  output logic                           last_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [slt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [slt_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import slt_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(DEPTH + 1);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int WW    = $clog2(MAX_WIDTH + 1);

  state_e state_q, state_d, div_ret_q, div_ret_d;

  logic [8:0]  height_q, width_q;
  logic [7:0]  half_q;
  logic [16:0] k_q;
  logic [HW-1:0] eff_h;
  logic [WW-1:0] eff_w;

  logic          func_q;
  logic [7:0]    pix_in_q;
  logic [IW-1:0] load_idx_q, emit_idx_q, total_q, area_q;
  logic [15:0]   row_sum_q;
  logic [23:0]   row_sq_q;

  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_q;

  logic              div_start;
  logic [DIV_W-1:0]  div_dvd, div_dvs;
  logic [6:0]        div_n;
  logic [DIV_W-1:0]  div_rem_q, div_quo_q, div_den_q;
  logic [6:0]        div_cnt_q;
  logic [DIV_W:0]    div_t;

  logic [SQRT_W-1:0] sq_v_q, sq_res_q, sq_bit_q;
  logic [4:0]        sq_cnt_q;
  logic [SQRT_W:0]   sq_t;

  logic [RW-1:0] r_q, x0_q, x1_q, x0_d, x1_d;
  logic [CW-1:0] c_q, y0_q, y1_q, y0_d, y1_d;
  logic [2:0]    rd_cnt_q;
  logic [23:0]   diff_q;
  logic [31:0]   sqd_q;
  logic [7:0]    p_q;
  logic [63:0]   a_q, b_q, num_q, den_q;
  logic [15:0]   mean_q, dev16;
  logic [31:0]   vq_q;
  logic [32:0]   term_q;
  logic          term_neg_q;
  logic [SQRT_W-1:0] var_d;
  logic          dev_neg_q;
  logic [15:0]   dev_mag;
  logic [33:0]   term_d;
  logic          res_q;

  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [7:0]    pix_rd_q;
  logic [23:0]   sum_rd_q, sum_wr;
  logic [31:0]   sq_rd_q, sq_wr;
  logic [15:0]   rs_new;
  logic [23:0]   rq_new;

  logic [7:0]  pix_mem [0:DEPTH-1];
  logic [23:0] sum_mem [0:DEPTH-1];
  logic [31:0] sq_mem  [0:DEPTH-1];

  logic accept, out_free, is_last;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                              input logic [CW-1:0] col);
    cell_addr = AW'(int'(row) * MAX_WIDTH + int'(col));
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_o || !out_stall_i;
  assign is_last     = (emit_idx_q + IW'(1)) == total_q;

  always_comb begin
    if (height_q == 9'd0) begin
      eff_h = HW'(1);
    end else if (int'(height_q) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(height_q);
    end
    if (width_q == 9'd0) begin
      eff_w = WW'(1);
    end else if (int'(width_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_q);
    end
  end

  always_comb begin
    int rr, cc, hw, hh, ww;
    rr = int'(div_quo_q[RW-1:0]);
    cc = int'(div_rem_q[CW-1:0]);
    hw = int'(half_q);
    hh = int'(eff_h);
    ww = int'(eff_w);
    x0_d = (rr > hw) ? RW'(rr - hw) : '0;
    y0_d = (cc > hw) ? CW'(cc - hw) : '0;
    x1_d = (rr + hw < hh - 1) ? RW'(rr + hw) : RW'(hh - 1);
    y1_d = (cc + hw < ww - 1) ? CW'(cc + hw) : CW'(ww - 1);
  end

  assign div_t  = {div_rem_q, div_quo_q[DIV_W-1]};
  assign sq_t   = {1'b0, sq_res_q} + {1'b0, sq_bit_q};
  assign dev16  = (sq_res_q[SQRT_W-1:16] != '0) ? 16'hFFFF : sq_res_q[15:0];
  assign dev_mag = dev16[15] ? {1'b0, dev16[14:0]} : 16'h8000 - dev16;
  assign var_d  = {vq_q, 16'h0000} + SQRT_W'(div_quo_q[15:0]);
  assign term_d = dev_neg_q ? 34'h080000000 - 34'(mul_q[31:0])
                            : 34'h080000000 + 34'(mul_q[31:0]);
  assign rs_new = ((c_q == '0) ? 16'd0 : row_sum_q) + 16'(pix_in_q);
  assign rq_new = ((c_q == '0) ? 24'd0 : row_sq_q) + 24'(16'(pix_in_q) * 16'(pix_in_q));
  assign sum_wr = 24'(rs_new) + ((r_q != '0) ? sum_rd_q : 24'd0);
  assign sq_wr  = 32'(rq_new) + ((r_q != '0) ? sq_rd_q : 32'd0);

  always_comb begin
    state_d   = state_q;
    div_ret_d = div_ret_q;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    div_n     = '0;
    mul_a     = 33'(eff_h);
    mul_b     = 32'(eff_w);
    mem_addr  = cell_addr(r_q, c_q);
    mem_we    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_TOTAL;
      end
      ST_TOTAL: begin
        div_dvd   = DIV_W'(func_q ? emit_idx_q : load_idx_q) << (DIV_W - IW);
        div_dvs   = DIV_W'(eff_w);
        div_n     = 7'(IW);
        div_ret_d = func_q ? ST_EM_WIN : ST_LD_RD;
        if (func_q == FUNC_LOAD) begin
          if (load_idx_q >= mul_q[IW-1:0]) begin
            state_d = ST_IDLE;
          end else begin
            state_d   = ST_DIV;
            div_start = 1'b1;
          end
        end else if (load_idx_q < mul_q[IW-1:0] || emit_idx_q >= mul_q[IW-1:0]) begin
          state_d = ST_IDLE;
        end else begin
          state_d   = ST_DIV;
          div_start = 1'b1;
        end
      end
      ST_DIV: begin
        if (div_cnt_q == 7'd1) state_d = div_ret_q;
      end
      ST_LD_RD: begin
        mem_addr = cell_addr(div_quo_q[RW-1:0] - RW'(1), div_rem_q[CW-1:0]);
        state_d  = ST_LD_WR;
      end
      ST_LD_WR: begin
        mem_we  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_EM_WIN: state_d = ST_EM_AREA;
      ST_EM_AREA: begin
        mul_a   = 33'(x1_q - x0_q) + 33'd1;
        mul_b   = 32'(y1_q - y0_q) + 32'd1;
        state_d = ST_EM_RD;
      end
      ST_EM_RD: begin
        unique case (rd_cnt_q)
          3'd0:    mem_addr = cell_addr(x1_q, y1_q);
          3'd1:    mem_addr = cell_addr((x0_q != '0) ? x0_q - RW'(1) : '0, y1_q);
          3'd2:    mem_addr = cell_addr(x1_q, (y0_q != '0) ? y0_q - CW'(1) : '0);
          3'd3:    mem_addr = cell_addr((x0_q != '0) ? x0_q - RW'(1) : '0,
                                        (y0_q != '0) ? y0_q - CW'(1) : '0);
          default: mem_addr = cell_addr(r_q, c_q);
        endcase
        if (rd_cnt_q == 3'd5) state_d = (area_q == IW'(1)) ? ST_EM_OUT : ST_EM_M0;
      end
      ST_EM_M0: begin
        mul_a   = 33'(area_q);
        mul_b   = sqd_q;
        state_d = ST_EM_M1;
      end
      ST_EM_M1: begin
        mul_a   = 33'(diff_q);
        mul_b   = 32'(diff_q);
        state_d = ST_EM_M2;
      end
      ST_EM_M2: begin
        mul_a   = 33'(area_q);
        mul_b   = 32'(area_q - IW'(1));
        state_d = ST_EM_M3;
      end
      ST_EM_M3: begin
        div_start = 1'b1;
        div_dvd   = {diff_q, 8'h00, 32'h0};
        div_dvs   = DIV_W'(area_q);
        div_n     = 7'd32;
        div_ret_d = ST_EM_MEAN;
        state_d   = ST_DIV;
      end
      ST_EM_MEAN: begin
        div_start = 1'b1;
        div_dvd   = num_q;
        div_dvs   = den_q;
        div_n     = 7'(DIV_W);
        div_ret_d = ST_EM_VQ;
        state_d   = ST_DIV;
      end
      ST_EM_VQ: begin
        div_start = 1'b1;
        div_dvd   = {div_rem_q[DIV_W-17:0], 16'h0000};
        div_dvs   = den_q;
        div_n     = 7'(DIV_W);
        div_ret_d = ST_EM_VF;
        state_d   = ST_DIV;
      end
      ST_EM_VF: state_d = ST_EM_SQRT;
      ST_EM_SQRT: begin
        if (sq_cnt_q == 5'd1) state_d = ST_EM_DEV;
      end
      ST_EM_DEV: begin
        mul_a   = 33'(k_q);
        mul_b   = 32'(dev_mag);
        state_d = ST_EM_TERM;
      end
      ST_EM_TERM: state_d = ST_EM_RHS;
      ST_EM_RHS: begin
        mul_a   = term_q;
        mul_b   = 32'(mean_q);
        state_d = ST_EM_CMP;
      end
      ST_EM_CMP: state_d = ST_EM_OUT;
      ST_EM_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_ret_q   <= ST_IDLE;
      height_q    <= RST_IMAGE_HEIGHT;
      width_q     <= RST_IMAGE_WIDTH;
      half_q      <= RST_HALF_WINDOW;
      k_q         <= RST_K_FACTOR;
      load_idx_q  <= '0;
      emit_idx_q  <= '0;
      row_sum_q   <= '0;
      row_sq_q    <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q   <= state_d;
      div_ret_q <= div_ret_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[8:0];
          CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[8:0];
          CFG_HALF_WINDOW:  half_q   <= cfg_data_i[7:0];
          CFG_K_FACTOR:     k_q      <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_TOTAL && func_q == FUNC_EMIT && load_idx_q >= mul_q[IW-1:0]
          && emit_idx_q >= mul_q[IW-1:0]) begin
        load_idx_q <= '0;
        emit_idx_q <= '0;
        row_sum_q  <= '0;
        row_sq_q   <= '0;
      end
      if (state_q == ST_LD_WR) begin
        row_sum_q  <= rs_new;
        row_sq_q   <= rq_new;
        load_idx_q <= load_idx_q + IW'(1);
      end
      if (state_q == ST_EM_OUT && out_free) begin
        out_valid_o <= 1'b1;
        if (is_last) begin
          load_idx_q <= '0;
          emit_idx_q <= '0;
          row_sum_q  <= '0;
          row_sq_q   <= '0;
        end else begin
          emit_idx_q <= emit_idx_q + IW'(1);
        end
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= 64'(mul_a) * 64'(mul_b);
    if (accept) begin
      func_q   <= func_i;
      pix_in_q <= pixel_in_i;
    end
    if (div_start) begin
      div_rem_q <= '0;
      div_quo_q <= div_dvd;
      div_den_q <= div_dvs;
      div_cnt_q <= div_n;
    end else if (state_q == ST_DIV) begin
      div_cnt_q <= div_cnt_q - 7'd1;
      if (div_t >= {1'b0, div_den_q}) begin
        div_rem_q <= DIV_W'(div_t - {1'b0, div_den_q});
        div_quo_q <= {div_quo_q[DIV_W-2:0], 1'b1};
      end else begin
        div_rem_q <= div_t[DIV_W-1:0];
        div_quo_q <= {div_quo_q[DIV_W-2:0], 1'b0};
      end
    end
    unique case (state_q)
      ST_TOTAL: total_q <= mul_q[IW-1:0];
      ST_LD_RD: begin
        r_q <= div_quo_q[RW-1:0];
        c_q <= div_rem_q[CW-1:0];
      end
      ST_EM_WIN: begin
        r_q  <= div_quo_q[RW-1:0];
        c_q  <= div_rem_q[CW-1:0];
        x0_q <= x0_d;
        x1_q <= x1_d;
        y0_q <= y0_d;
        y1_q <= y1_d;
      end
      ST_EM_AREA: rd_cnt_q <= '0;
      ST_EM_RD: begin
        rd_cnt_q <= rd_cnt_q + 3'd1;
        unique case (rd_cnt_q)
          3'd0: area_q <= mul_q[IW-1:0];
          3'd1: begin
            diff_q <= sum_rd_q;
            sqd_q  <= sq_rd_q;
          end
          3'd2: begin
            if (x0_q != '0) begin
              diff_q <= diff_q - sum_rd_q;
              sqd_q  <= sqd_q - sq_rd_q;
            end
          end
          3'd3: begin
            if (y0_q != '0) begin
              diff_q <= diff_q - sum_rd_q;
              sqd_q  <= sqd_q - sq_rd_q;
            end
          end
          3'd4: begin
            if (x0_q != '0 && y0_q != '0) begin
              diff_q <= diff_q + sum_rd_q;
              sqd_q  <= sqd_q + sq_rd_q;
            end
          end
          default: begin
            p_q   <= pix_rd_q;
            res_q <= 1'b0;
          end
        endcase
      end
      ST_EM_M1: a_q <= mul_q;
      ST_EM_M2: b_q <= mul_q;
      ST_EM_M3: begin
        den_q <= mul_q;
        num_q <= (a_q > b_q) ? a_q - b_q : 64'd0;
      end
      ST_EM_MEAN: mean_q <= (div_quo_q[DIV_W-1:16] != '0) ? 16'hFFFF : div_quo_q[15:0];
      ST_EM_VQ:   vq_q <= (div_quo_q[DIV_W-1:32] != '0) ? 32'hFFFF_FFFF : div_quo_q[31:0];
      ST_EM_VF: begin
        sq_v_q   <= var_d;
        sq_res_q <= '0;
        sq_bit_q <= SQRT_W'(1) << (SQRT_W - 2);
        sq_cnt_q <= 5'(SQRT_ITR);
      end
      ST_EM_SQRT: begin
        sq_cnt_q <= sq_cnt_q - 5'd1;
        sq_bit_q <= sq_bit_q >> 2;
        if ({1'b0, sq_v_q} >= sq_t) begin
          sq_v_q   <= SQRT_W'({1'b0, sq_v_q} - sq_t);
          sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
        end else begin
          sq_res_q <= sq_res_q >> 1;
        end
      end
      ST_EM_DEV:  dev_neg_q <= ~dev16[15];
      ST_EM_TERM: begin
        term_neg_q <= term_d[33];
        term_q     <= term_d[33] ? 33'(34'd0 - term_d) : term_d[32:0];
      end
      ST_EM_CMP: begin
        res_q <= term_neg_q ? (p_q != 8'd0 || mean_q != 16'd0)
                            : ((64'(p_q) << 39) > mul_q);
      end
      ST_EM_OUT: begin
        if (out_free) begin
          bin_pixel_o <= res_q ? BIN_FG : BIN_BG;
          last_o      <= is_last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pix_mem[mem_addr] <= pix_in_q;
      sum_mem[mem_addr] <= sum_wr;
      sq_mem[mem_addr]  <= sq_wr;
    end
    pix_rd_q <= pix_mem[mem_addr];
    sum_rd_q <= sum_mem[mem_addr];
    sq_rd_q  <= sq_mem[mem_addr];
  end

endmodule
